// File: src/generalized_advantage_estimator_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the generalised advantage estimator
// Implication and next-cycle implication checks, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef GENERALIZED_ADVANTAGE_ESTIMATOR_MACROS_SVH
`define GENERALIZED_ADVANTAGE_ESTIMATOR_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define GAE_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define GAE_ASSERT_NXT(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GAE_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg)
`define GAE_ASSERT_NXT(lbl, ck, rstn, ante, cons, msg)
`endif

`endif

// File: src/gae_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gae_pkg
// Shared widths, types and fixed-point helpers of the advantage estimator.
// ---------------------------------------------------------------------------
package gae_pkg;

	localparam int AGENT_W        = 6;
	localparam int DATA_W         = 32;
	localparam int FACTOR_W       = 17;
	localparam int DECAY_W        = 18;
	localparam int FRAC_W         = 16;
	localparam int AGENTS_DEFAULT = 64;
	localparam int QUEUE_DEPTH    = 4;

	// stream payload layout
	localparam int IN_FIELDS_W  = AGENT_W + 4 * DATA_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int IN_TUSER_W   = 3;
	localparam int OUT_FIELDS_W = AGENT_W + 2 * DATA_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	// configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [FACTOR_W-1:0] DISCOUNT_RESET    = 17'd64881;
	localparam logic [FACTOR_W-1:0] TRACE_DECAY_RESET = 17'd62259;

	typedef enum logic [0:0] {
		REG_DISCOUNT    = 1'b0,
		REG_TRACE_DECAY = 1'b1
	} reg_idx_t;

	// classified sample handed from the front end to the back end
	typedef struct packed {
		logic [AGENT_W-1:0]       agent;
		logic signed [DATA_W-1:0] reward_adj;
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] bootstrap_value;
		logic                     episode_done;
		logic                     final_step;
		logic                     in_range;
	} item_t;

	// back end activity, watched by the top level checks
	typedef struct packed {
		logic               rd_en;
		logic               rd_inside;
		logic [AGENT_W-1:0] rd_agent;
		logic               s3_valid;
	} back_status_t;

	// Q16.16 times unsigned Q1.16, rounded to nearest with ties upward
	function automatic logic signed [DATA_W+1:0] mul_q16_discount(
		input logic signed [DATA_W-1:0] a,
		input logic [FACTOR_W-1:0]      f
	);
		logic signed [DATA_W+FACTOR_W:0] pa;
		logic signed [DATA_W+FACTOR_W:0] pf;
		logic signed [DATA_W+FACTOR_W:0] p;
		pa = (DATA_W+FACTOR_W+1)'(a);
		pf = (DATA_W+FACTOR_W+1)'({1'b0, f});
		p  = pa * pf + (DATA_W+FACTOR_W+1)'(1 << (FRAC_W - 1));
		return p[DATA_W+FACTOR_W:FRAC_W];
	endfunction

	// clamp to the signed 32-bit range
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W+4:0] v);
		logic signed [DATA_W+4:0] hi;
		logic signed [DATA_W+4:0] lo;
		hi = (DATA_W+5)'(64'sd2147483647);
		lo = (DATA_W+5)'(-64'sd2147483648);
		if (v > hi) begin
			return {1'b0, {(DATA_W-1){1'b1}}};
		end else if (v < lo) begin
			return {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			return v[DATA_W-1:0];
		end
	endfunction

endpackage

// File: src/gae_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gae_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module gae_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

endmodule

// File: src/gae_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gae_front
// Input stage: takes samples, folds in the truncation bootstrap, classifies.
// ---------------------------------------------------------------------------
module gae_front #(
	parameter int AGENTS = gae_pkg::AGENTS_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// agent, reward, value, bootstrap_value, trunc_value (low bits first)
	input  logic [gae_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// episode_done, final_step, trunc_valid (low bit first)
	input  logic [gae_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
	input  logic [gae_pkg::FACTOR_W-1:0]       discount,
	input  logic                               q_full,
	output logic                               q_push,
	output gae_pkg::item_t                     q_item
);

	import gae_pkg::*;

	localparam int OFS_REWARD = AGENT_W;
	localparam int OFS_VALUE  = OFS_REWARD + DATA_W;
	localparam int OFS_BOOT   = OFS_VALUE + DATA_W;
	localparam int OFS_TRUNC  = OFS_BOOT + DATA_W;

	logic                     valid_s1;
	logic [AGENT_W-1:0]       agent_s1;
	logic signed [DATA_W-1:0] reward_s1;
	logic signed [DATA_W-1:0] value_s1;
	logic signed [DATA_W-1:0] boot_s1;
	logic signed [DATA_W-1:0] trunc_value_s1;
	logic                     done_s1;
	logic                     final_s1;
	logic                     trunc_s1;
	logic                     take;
	logic signed [DATA_W+1:0] trunc_prod;
	logic signed [DATA_W-1:0] reward_adj;

	assign s_axis_tready = !valid_s1 || !q_full;
	assign take          = s_axis_tvalid && s_axis_tready;
	assign q_push        = valid_s1 && !q_full;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	// sample capture
	always_ff @(posedge clk) begin
		if (take) begin
			agent_s1       <= s_axis_tdata[AGENT_W-1:0];
			reward_s1      <= s_axis_tdata[OFS_REWARD +: DATA_W];
			value_s1       <= s_axis_tdata[OFS_VALUE +: DATA_W];
			boot_s1        <= s_axis_tdata[OFS_BOOT +: DATA_W];
			trunc_value_s1 <= s_axis_tdata[OFS_TRUNC +: DATA_W];
			done_s1        <= s_axis_tuser[0];
			final_s1       <= s_axis_tuser[1];
			trunc_s1       <= s_axis_tuser[2];
		end
	end

	// reward plus discounted truncation value
	assign trunc_prod = mul_q16_discount(trunc_value_s1, discount);
	assign reward_adj = trunc_s1
		? sat32((DATA_W+5)'(reward_s1) + (DATA_W+5)'(trunc_prod))
		: reward_s1;

	always_comb begin
		q_item.agent           = agent_s1;
		q_item.reward_adj      = reward_adj;
		q_item.value           = value_s1;
		q_item.bootstrap_value = boot_s1;
		q_item.episode_done    = done_s1;
		q_item.final_step      = final_s1;
		q_item.in_range        = (32'(agent_s1) < 32'(AGENTS));
	end

endmodule

// File: src/gae_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gae_queue
// Short FIFO between the front and back ends.
// ---------------------------------------------------------------------------
module gae_queue (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     push,
	input  gae_pkg::item_t                           item_in,
	input  logic                                     pop,
	output logic                                     valid,
	output logic                                     full,
	output gae_pkg::item_t                           head,
	output logic [$clog2(gae_pkg::QUEUE_DEPTH+1)-1:0] count
);

	import gae_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign valid = (count_q != '0);
	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head  = mem_q[rd_ptr_q];
	assign count = count_q;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

endmodule

// File: src/gae_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gae_back
// Per-agent state pipeline: state read, products, advantage, output register.
// ---------------------------------------------------------------------------
module gae_back #(
	parameter int AGENTS = gae_pkg::AGENTS_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [gae_pkg::FACTOR_W-1:0]       discount,
	input  logic [gae_pkg::DECAY_W-1:0]        decay,
	input  logic                               q_valid,
	input  gae_pkg::item_t                     q_head,
	output logic                               q_pop,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// agent_out, advantage, return_value (low bits first)
	output logic [gae_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	output gae_pkg::back_status_t              status
);

	import gae_pkg::*;

	localparam int STATE_DEPTH = (AGENTS < (1 << AGENT_W)) ? AGENTS : (1 << AGENT_W);
	localparam int IDX_W       = (STATE_DEPTH > 1) ? $clog2(STATE_DEPTH) : 1;
	localparam int RAM_W       = 2 * DATA_W;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELDS_W;

	// running value times the combined decay factor, rounded
	function automatic logic signed [DATA_W+2:0] mul_q16_decay(
		input logic signed [DATA_W-1:0] a,
		input logic [DECAY_W-1:0]       f
	);
		logic signed [DATA_W+DECAY_W:0] pa;
		logic signed [DATA_W+DECAY_W:0] pf;
		logic signed [DATA_W+DECAY_W:0] p;
		pa = (DATA_W+DECAY_W+1)'(a);
		pf = (DATA_W+DECAY_W+1)'({1'b0, f});
		p  = pa * pf + (DATA_W+DECAY_W+1)'(1 << (FRAC_W - 1));
		return p[DATA_W+DECAY_W:FRAC_W];
	endfunction

	logic                     adv_en;
	logic                     hazard;
	logic                     issue;
	logic [RAM_W-1:0]         ram_rdata;
	logic                     ram_we;

	// stage 1: state word arrives
	logic                     valid_s1;
	item_t                    item_s1;
	logic                     fwd;
	logic signed [DATA_W-1:0] run_st;
	logic signed [DATA_W-1:0] next_st;
	logic signed [DATA_W-1:0] run_sel;
	logic signed [DATA_W-1:0] next_sel;

	// stage 2: products registered
	logic                     valid_s2;
	logic [AGENT_W-1:0]       agent_s2;
	logic                     inside_s2;
	logic                     done_s2;
	logic signed [DATA_W-1:0] value_s2;
	logic signed [DATA_W:0]   rv_s2;
	logic signed [DATA_W+1:0] next_prod_s2;
	logic signed [DATA_W+2:0] run_prod_s2;
	logic signed [DATA_W-1:0] delta;
	logic signed [DATA_W-1:0] adv;

	// stage 3: advantage registered
	logic                     valid_s3;
	logic [AGENT_W-1:0]       agent_s3;
	logic                     inside_s3;
	logic signed [DATA_W-1:0] adv_s3;
	logic signed [DATA_W-1:0] value_s3;

	// output register
	logic                     out_valid_q;
	logic [AGENT_W-1:0]       out_agent_q;
	logic signed [DATA_W-1:0] out_adv_q;
	logic signed [DATA_W-1:0] out_ret_q;

	// whole pipeline moves when the output slot frees up
	assign adv_en = !out_valid_q || m_axis_tready;
	// the agent in stage 1 writes its state only from stage 2, too late for a read now
	assign hazard = valid_s1 && q_head.in_range && (q_head.agent == item_s1.agent);
	assign issue  = adv_en && q_valid && !hazard;
	assign q_pop  = issue;

	gae_ram #(
		.WIDTH (RAM_W),
		.DEPTH (STATE_DEPTH)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (agent_s2[IDX_W-1:0]),
		.wdata ({adv, value_s2}),
		.re    (issue),
		.raddr (q_head.agent[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	assign ram_we = valid_s2 && inside_s2 && adv_en;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv_en) begin
			valid_s1    <= issue;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			item_s1 <= q_head;
		end
	end

	// state select: forward the item just written, else the RAM word
	assign fwd = valid_s3 && inside_s3 && (agent_s3 == item_s1.agent);

	always_comb begin
		run_st  = fwd ? adv_s3 : $signed(ram_rdata[RAM_W-1:DATA_W]);
		next_st = fwd ? value_s3 : $signed(ram_rdata[DATA_W-1:0]);
		if (item_s1.final_step) begin
			next_sel = item_s1.bootstrap_value;
			run_sel  = '0;
		end else if (item_s1.in_range) begin
			next_sel = next_st;
			run_sel  = run_st;
		end else begin
			next_sel = '0;
			run_sel  = '0;
		end
	end

	// stage 1 -> 2: both products and the reward minus value
	always_ff @(posedge clk) begin
		if (adv_en) begin
			agent_s2     <= item_s1.agent;
			inside_s2    <= item_s1.in_range;
			done_s2      <= item_s1.episode_done;
			value_s2     <= item_s1.value;
			rv_s2        <= (DATA_W+1)'(item_s1.reward_adj) - (DATA_W+1)'(item_s1.value);
			next_prod_s2 <= mul_q16_discount(next_sel, discount);
			run_prod_s2  <= mul_q16_decay(run_sel, decay);
		end
	end

	// temporal difference and advantage, both clamped
	assign delta = sat32((DATA_W+5)'(rv_s2)
		+ (done_s2 ? (DATA_W+5)'(0) : (DATA_W+5)'(next_prod_s2)));
	assign adv   = sat32((DATA_W+5)'(delta)
		+ (done_s2 ? (DATA_W+5)'(0) : (DATA_W+5)'(run_prod_s2)));

	// stage 2 -> 3
	always_ff @(posedge clk) begin
		if (adv_en) begin
			agent_s3  <= agent_s2;
			inside_s3 <= inside_s2;
			adv_s3    <= adv;
			value_s3  <= value_s2;
		end
	end

	// output register with the return
	always_ff @(posedge clk) begin
		if (adv_en) begin
			out_agent_q <= agent_s3;
			out_adv_q   <= adv_s3;
			out_ret_q   <= sat32((DATA_W+5)'(adv_s3) + (DATA_W+5)'(value_s3));
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_ret_q, out_adv_q, out_agent_q};

	always_comb begin
		status.rd_en     = issue;
		status.rd_inside = q_head.in_range;
		status.rd_agent  = q_head.agent;
		status.s3_valid  = valid_s3;
	end

endmodule

// File: src/generalized_advantage_estimator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// generalized_advantage_estimator
// GAE over reverse-ordered rollout samples, signed Q16.16, saturating.
// ---------------------------------------------------------------------------
// Usage:
//   Samples enter on s_axis (tdata: agent, reward, value, bootstrap_value,
//   trunc_value; tuser: episode_done, final_step, trunc_valid), latest time
//   step first. Each sample yields one result on m_axis (agent_out,
//   advantage, return_value), in input order.
//   discount and trace_decay are written over the APB port at 0x0 and 0x4;
//   the user must write them only while no sample is in flight, as the
//   block does not enforce it. Throughput is one sample per cycle while
//   m_axis does not stall; a sample of the agent in stage 1 of the back
//   end waits, set by the registered read of the per-agent state RAM.
//   Reset empties the pipeline and loads the default factors; per-agent
//   state is undefined until that agent's first sample has passed.
//   If m_axis stalls, the back end holds and the four-entry queue plus the
//   input register keep taking samples until they fill.
// ---------------------------------------------------------------------------
`include "generalized_advantage_estimator_macros.svh"

module generalized_advantage_estimator #(
	parameter int AGENTS = gae_pkg::AGENTS_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// sample stream
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// agent, reward, value, bootstrap_value, trunc_value (low bits first)
	input  logic [gae_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// episode_done, final_step, trunc_valid (low bit first)
	input  logic [gae_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
	// result stream
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// agent_out, advantage, return_value (low bits first)
	output logic [gae_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// register port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [gae_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [gae_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [gae_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready
);

	import gae_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [FACTOR_W-1:0]   discount_q;
	logic [FACTOR_W-1:0]   trace_decay_q;
	logic [DECAY_W-1:0]    decay_q;
	logic [2*FACTOR_W-1:0] decay_prod;
	logic                  cfg_wr;
	reg_idx_t              cfg_idx;

	logic                  q_push;
	logic                  q_pop;
	logic                  q_valid;
	logic                  q_full;
	logic [CNT_W-1:0]      q_count;
	item_t                 front_item;
	item_t                 q_head;
	back_status_t          st;

	// register file
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			discount_q    <= DISCOUNT_RESET;
			trace_decay_q <= TRACE_DECAY_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_DISCOUNT:    discount_q    <= pwdata[FACTOR_W-1:0];
				REG_TRACE_DECAY: trace_decay_q <= pwdata[FACTOR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_DISCOUNT:    prdata = APB_DATA_W'(discount_q);
			REG_TRACE_DECAY: prdata = APB_DATA_W'(trace_decay_q);
			default:         prdata = '0;
		endcase
	end

	// combined decay, rounded to .16; settles while the block is idle
	assign decay_prod = (2*FACTOR_W)'(discount_q) * (2*FACTOR_W)'(trace_decay_q)
		+ (2*FACTOR_W)'(1 << (FRAC_W - 1));

	always_ff @(posedge clk) begin
		decay_q <= decay_prod[2*FACTOR_W-1:FRAC_W];
	end

	gae_front #(
		.AGENTS (AGENTS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.discount      (discount_q),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (front_item)
	);

	gae_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.item_in (front_item),
		.pop     (q_pop),
		.valid   (q_valid),
		.full    (q_full),
		.head    (q_head),
		.count   (q_count)
	);

	gae_back #(
		.AGENTS (AGENTS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.discount      (discount_q),
		.decay         (decay_q),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.status        (st)
	);

	// checks
	`GAE_ASSERT_NXT(a_no_consecutive_state_read, clk, arst_n, st.rd_en && st.rd_inside, !(st.rd_en && (st.rd_agent == $past(st.rd_agent))), "state read of an agent whose update is still pending")
	`GAE_ASSERT_IMP(a_result_from_stage3, clk, arst_n, $rose(m_axis_tvalid), $past(st.s3_valid), "result appeared without an item in stage 3")
	`GAE_ASSERT_IMP(a_queue_bound, clk, arst_n, 1'b1, q_count <= CNT_W'(QUEUE_DEPTH), "queue fill level above its depth")

endmodule

// File: verif/gae_result_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gae_result_checker
// Watches the sample, result and register channels of the advantage
// estimator. It keeps its own per-agent advantage state and factors, and
// predicts one result per sample transfer. Each result transfer is compared
// field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module gae_result_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	input  logic                             s_axis_tready,
	// agent, reward, value, bootstrap_value, trunc_value (low bits first)
	input  logic [gae_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// episode_done, final_step, trunc_valid (low bit first)
	input  logic [gae_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// agent_out, advantage, return_value (low bits first)
	input  logic [gae_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [gae_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [gae_pkg::APB_DATA_W-1:0]   pwdata,
	input  logic                             pready,
	output int                               fail_count,
	output int                               pending
);

	import gae_pkg::*;

	typedef struct packed {
		logic [AGENT_W-1:0]       agent;
		logic signed [DATA_W-1:0] advantage;
		logic signed [DATA_W-1:0] return_value;
	} gae_result_t;

	gae_result_t expected_results [$];

	logic [FACTOR_W-1:0]      gamma_q;
	logic [FACTOR_W-1:0]      lambda_q;
	logic signed [DATA_W-1:0] agent_running_adv [AGENTS_DEFAULT];
	logic signed [DATA_W-1:0] agent_next_value [AGENTS_DEFAULT];

	// round to nearest Q.16, ties upward
	function automatic longint round_q16(input longint p);
		return (p + 64'sd32768) >>> 16;
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end else if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// advantage and return for one sample; updates the agent's state
	function automatic gae_result_t predict_advantage(
		input logic [IN_TDATA_W-1:0] tdata,
		input logic [IN_TUSER_W-1:0] tuser
	);
		logic [AGENT_W-1:0]       agent;
		logic signed [DATA_W-1:0] reward_in, value_in, boot_in, trunc_in;
		logic                     done, last_step, trunc;
		longint                   value, nxt, run, r, delta, adv, ret, gamma, decay;
		gae_result_t              res;
		agent     = tdata[AGENT_W-1:0];
		reward_in = tdata[AGENT_W +: DATA_W];
		value_in  = tdata[AGENT_W+DATA_W +: DATA_W];
		boot_in   = tdata[AGENT_W+2*DATA_W +: DATA_W];
		trunc_in  = tdata[AGENT_W+3*DATA_W +: DATA_W];
		done      = tuser[0];
		last_step = tuser[1];
		trunc     = tuser[2];
		value     = longint'(value_in);
		gamma     = longint'({1'b0, gamma_q});
		run       = 0;
		if (last_step) begin
			nxt = longint'(boot_in);
		end else begin
			nxt = longint'(agent_next_value[agent]);
			run = longint'(agent_running_adv[agent]);
		end
		// truncation bootstrap folded into the reward
		r = longint'(reward_in);
		if (trunc) begin
			r = clamp32(r + round_q16(longint'(trunc_in) * gamma));
		end
		delta = r - value;
		if (!done) begin
			delta += round_q16(nxt * gamma);
		end
		delta = clamp32(delta);
		decay = round_q16(gamma * longint'({1'b0, lambda_q}));
		adv = delta;
		if (!done) begin
			adv += round_q16(run * decay);
		end
		adv = clamp32(adv);
		ret = clamp32(adv + value);
		agent_running_adv[agent] = adv[DATA_W-1:0];
		agent_next_value[agent]  = value_in;
		res.agent        = agent;
		res.advantage    = adv[DATA_W-1:0];
		res.return_value = ret[DATA_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		fail_count++;
		$display("%0t ns: result mismatch: %s", $time, what);
	endtask

	// register writes, predictions on sample transfers, checks on result transfers
	always @(posedge clk or negedge arst_n) begin
		gae_result_t want;
		gae_result_t got;
		if (!arst_n) begin
			gamma_q    = DISCOUNT_RESET;
			lambda_q   = TRACE_DECAY_RESET;
			fail_count = 0;
			pending    = 0;
			expected_results.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[2]))
					REG_DISCOUNT:    gamma_q  = pwdata[FACTOR_W-1:0];
					REG_TRACE_DECAY: lambda_q = pwdata[FACTOR_W-1:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results.push_back(predict_advantage(s_axis_tdata, s_axis_tuser));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.agent        = m_axis_tdata[AGENT_W-1:0];
				got.advantage    = m_axis_tdata[AGENT_W +: DATA_W];
				got.return_value = m_axis_tdata[AGENT_W+DATA_W +: DATA_W];
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result agent %0d", got.agent));
				end else begin
					want = expected_results.pop_front();
					if (got.agent !== want.agent) begin
						report_mismatch($sformatf("agent_out %0d, expected %0d",
							got.agent, want.agent));
					end
					if (got.advantage !== want.advantage) begin
						report_mismatch($sformatf("agent %0d advantage %h, expected %h",
							want.agent, got.advantage, want.advantage));
					end
					if (got.return_value !== want.return_value) begin
						report_mismatch($sformatf("agent %0d return %h, expected %h",
							want.agent, got.return_value, want.return_value));
					end
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the advantage estimator. Directed corner samples
// are followed by randomised rollouts (reverse time order, all agents of a
// step together) under several discount and decay settings, with random
// sample gaps and result back-pressure. Checking is done by gae_result_checker.
// ---------------------------------------------------------------------------
module tb_top;
	import gae_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [AGENT_W-1:0]       agent;
		logic signed [DATA_W-1:0] reward;
		logic signed [DATA_W-1:0] value;
		logic                     episode_done;
		logic                     final_step;
		logic signed [DATA_W-1:0] bootstrap_value;
		logic                     trunc_valid;
		logic signed [DATA_W-1:0] trunc_value;
	} rollout_sample_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [APB_ADDR_W-1:0]  paddr = '0;
	logic [APB_DATA_W-1:0]  pwdata = '0;
	logic [APB_DATA_W-1:0]  prdata;
	logic                   pready;

	int fail_count;
	int pending;
	int items_sent = 0;
	int cycle_count = 0;
	int rx_hold_left = 0;
	bit quiet = 1'b0;
	bit agent_primed [AGENTS_DEFAULT];

	generalized_advantage_estimator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	gae_result_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side: random stall bursts, one long hold on request, none when quiet
	initial begin
		int gap;
		gap = 0;
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				m_axis_tready <= 1'b0;
			end else if (quiet) begin
				m_axis_tready <= 1'b1;
			end else if (gap > 0) begin
				gap--;
				m_axis_tready <= 1'b0;
			end else if ($urandom_range(0, 7) == 0) begin
				gap = $urandom_range(1, 11) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Q16.16 operand: mostly modest, sometimes wide, sometimes at the limits
	function automatic logic [DATA_W-1:0] rand_q16();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					3: return 32'hFFFF_FFFF;
					default: return 32'h0001_0000;
				endcase
			end
			1, 2: return $urandom;
			3: return 32'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;
			default: return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
		endcase
	endfunction

	function automatic rollout_sample_t make_sample(
		input int agent, input logic [DATA_W-1:0] reward, input logic [DATA_W-1:0] value,
		input bit done, input bit last_step, input logic [DATA_W-1:0] boot,
		input bit trunc, input logic [DATA_W-1:0] trunc_val
	);
		rollout_sample_t s;
		s.agent           = AGENT_W'(agent);
		s.reward          = reward;
		s.value           = value;
		s.episode_done    = done;
		s.final_step      = last_step;
		s.bootstrap_value = boot;
		s.trunc_valid     = trunc;
		s.trunc_value     = trunc_val;
		return s;
	endfunction

	// offer one sample from a falling edge; returns at the falling edge after its transfer
	task automatic push_sample(input rollout_sample_t s);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_TDATA_W'({s.trunc_value, s.bootstrap_value, s.value,
			s.reward, s.agent});
		s_axis_tuser  <= {s.trunc_valid, s.final_step, s.episode_done};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		agent_primed[s.agent] = 1'b1;
		items_sent++;
	endtask

	task automatic sender_gap();
		int n;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 11);
			s_axis_tvalid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// stop offering and wait until every predicted result has been taken
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [FACTOR_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_W'({idx, 2'b00});
		pwdata  <= APB_DATA_W'(val);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic write_factors(input logic [FACTOR_W-1:0] gamma,
		input logic [FACTOR_W-1:0] lambda);
		wait_drained();
		apb_write(REG_DISCOUNT, gamma);
		apb_write(REG_TRACE_DECAY, lambda);
	endtask

	// one rollout: a set of agents over a few steps, latest step (final) first
	task automatic send_rollout();
		int pool [AGENTS_DEFAULT];
		int n_agents, n_steps, j, t, k, step;
		rollout_sample_t s;
		case ($urandom_range(0, 3))
			0: n_agents = 1;
			1: n_agents = $urandom_range(2, 4);
			default: n_agents = $urandom_range(5, AGENTS_DEFAULT);
		endcase
		n_steps = $urandom_range(1, (n_agents < 8) ? 12 : 3);
		for (k = 0; k < AGENTS_DEFAULT; k++) begin
			pool[k] = k;
		end
		for (k = 0; k < n_agents; k++) begin
			j = $urandom_range(k, AGENTS_DEFAULT - 1);
			t = pool[k];
			pool[k] = pool[j];
			pool[j] = t;
		end
		for (step = 0; step < n_steps; step++) begin
			for (k = 0; k < n_agents; k++) begin
				// occasionally drop a sample to break the pattern
				if (step > 0 && $urandom_range(0, 15) == 0) begin
					continue;
				end
				s = make_sample(pool[k], rand_q16(), rand_q16(),
					$urandom_range(0, 5) == 0, step == 0, rand_q16(),
					$urandom_range(0, 5) == 0, rand_q16());
				push_sample(s);
				sender_gap();
			end
		end
	endtask

	// mostly rollouts, some loose samples; unseen agents only get final steps
	task automatic run_phase(input int n_items);
		int target, a;
		bit last_step;
		target = items_sent + n_items;
		while (items_sent < target) begin
			if ($urandom_range(0, 9) == 0) begin
				a = $urandom_range(0, AGENTS_DEFAULT - 1);
				last_step = agent_primed[a] ? 1'($urandom_range(0, 1)) : 1'b1;
				push_sample(make_sample(a, $urandom, $urandom, 1'($urandom_range(0, 1)),
					last_step, $urandom, 1'($urandom_range(0, 1)), $urandom));
				sender_gap();
			end else begin
				send_rollout();
			end
		end
	endtask

	initial begin : stimulus
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed corners at the reset factors
		// saturation upward and downward on a final step, with truncation
		push_sample(make_sample(0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1, 32'h7FFF_FFFF,
			1, 32'h7FFF_FFFF));
		push_sample(make_sample(63, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1, 32'h8000_0000,
			1, 32'h8000_0000));
		// termination on a final step ignores the bootstrap
		push_sample(make_sample(63, 32'h0001_0000, 32'h0000_8000, 1, 1, 32'h7FFF_FFFF,
			0, 32'h0));
		// same agent back to back, reading saturated state
		push_sample(make_sample(0, 32'h0001_0000, 32'h0000_8000, 0, 0, 32'h0, 0, 32'h0));
		push_sample(make_sample(0, 32'hFFFF_0000, 32'h0002_0000, 0, 0, 32'h0, 0, 32'h0));
		// termination with truncation on a non-final step
		push_sample(make_sample(0, 32'h0000_4000, 32'hFFFF_8000, 1, 0, 32'h0,
			1, 32'h0003_0000));
		push_sample(make_sample(63, 32'h0, 32'h0, 0, 0, 32'h0, 1, 32'hFFFF_FFFF));
		// two agents interleaved
		push_sample(make_sample(5, 32'h0000_8000, 32'h0001_8000, 0, 1, 32'h0000_8000,
			0, 32'h0));
		push_sample(make_sample(6, 32'hFFFF_8000, 32'h0, 0, 1, 32'hFFFF_FFFF, 0, 32'h0));
		push_sample(make_sample(5, 32'h0000_0001, 32'h0000_0003, 0, 0, 32'h0, 0, 32'h0));
		push_sample(make_sample(6, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 32'h0,
			1, 32'h7FFF_FFFF));
		push_sample(make_sample(5, 32'h0, 32'h0, 1, 1, 32'h0, 0, 32'h0));
		push_sample(make_sample(6, 32'h8000_0000, 32'h8000_0000, 0, 0, 32'h8000_0000,
			1, 32'h8000_0000));
		push_sample(make_sample(42, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1, 32'hFFFF_FFFF,
			0, 32'h0000_0001));

		run_phase(170);

		// unity factors, with a long result-side hold while samples keep coming
		write_factors(17'd65536, 17'd65536);
		rx_hold_left = 400;
		run_phase(190);

		// zero factors
		write_factors(17'd0, 17'd0);
		run_phase(150);

		// gains above one
		write_factors(17'h1FFFF, 17'h1FFFF);
		run_phase(150);

		write_factors(17'd0, 17'd65536);
		run_phase(110);

		write_factors(17'd65536, 17'd0);
		run_phase(110);

		// random factors, last stretch without any idling
		write_factors(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)));
		run_phase(110);
		quiet = 1'b1;
		run_phase(110);

		wait_drained();
		repeat (20) @(negedge clk);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
